// ===== rtl/vaf_pkg.sv =====
// Package for the vector angle block: shared widths, the beat tag struct
// and the elaboration-time arctangent table. No dependencies.
package vaf_pkg;

  // Widths of the fixed part of the datapath (after norm fitting)
  localparam int FIT_BITS     = 32;  // fitted norms, dot magnitude, first root
  localparam int QUO_BITS     = 30;  // cosine quotient bits below the integer bit
  localparam int CM_BITS      = 31;  // cosine magnitude, Q1.30 (max 1.0)
  localparam int SN_BITS      = 31;  // sine magnitude root
  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_W     = 34;  // signed x, y, z in the rotation chain

  // Flags that ride along with each beat
  typedef struct packed {
    logic inval;  // zero-length vector seen
    logic dneg;   // dot product negative
    logic sat;    // cosine magnitude clamps to 1.0
  } tag_t;

  // Restoring unsigned divide, used only for constants at elaboration
  function automatic logic [63:0] cdiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      q = {q[62:0], 1'b0};
      if (r >= b) begin
        r    = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-sh) in Q60 by the power series
  function automatic logic [63:0] atan_pow2(input int sh);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      e = sh * (2 * k + 1);
      if (e <= 60) begin
        term = cdiv(64'd1 << (60 - e), 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
    end
    return acc;
  endfunction

  // atan(1/n) in Q60 by the power series
  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] term;
    p   = cdiv(64'd1 << 60, n);
    acc = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = cdiv(p, 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
        p = cdiv(p, n * n);
      end
    end
    return acc;
  endfunction

  // floor(atan(2^-i) / pi * 2^32), with the first entry fixed at pi/4 (an eighth of a turn)
  function automatic logic [31:0] atan_entry(input int i);
    logic [63:0] pi_q;
    logic [63:0] rem;
    logic [31:0] q;
    pi_q = 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);
    rem  = atan_pow2(i);
    q    = '0;
    for (int b = 0; b < 32; b++) begin
      rem = {rem[62:0], 1'b0};
      q   = {q[30:0], 1'b0};
      if (rem >= pi_q) begin
        rem  = rem - pi_q;
        q[0] = 1'b1;
      end
    end
    if (i == 0) q = 32'h4000_0000;
    return q;
  endfunction

endpackage

// ===== rtl/vaf_front.sv =====
// Front end: component magnitudes, squares and component products, norms,
// dot product sign and magnitude, and fitting of the norms to 32 bits.
// Depends on vaf_pkg.
module vaf_front #(
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic signed [CW-1:0]  ax_i,
  input  logic signed [CW-1:0]  ay_i,
  input  logic signed [CW-1:0]  az_i,
  input  logic signed [CW-1:0]  bx_i,
  input  logic signed [CW-1:0]  by_i,
  input  logic signed [CW-1:0]  bz_i,
  output logic                  vld_o,
  output logic [31:0]           na_o,
  output logic [31:0]           nb_o,
  output logic [31:0]           dmag_o,
  output vaf_pkg::tag_t         tag_o
);

  localparam int NW = 2 * CW;
  localparam int TW = $clog2(NW + 1);

  logic [CW-1:0] ra [3];
  logic [CW-1:0] rb [3];
  logic [CW-1:0] ma [3];
  logic [CW-1:0] mb [3];

  logic [4:0]    vld_r;
  logic [CW-1:0] am_r [3];
  logic [CW-1:0] bm_r [3];
  logic [2:0]    sg_r;
  logic [NW-1:0] sqa_r [3];
  logic [NW-1:0] sqb_r [3];
  logic [NW-1:0] pr_r [3];
  logic [2:0]    sg2_r;
  logic [NW-1:0] na_r, nb_r, pos_r, neg_r;
  logic [NW-1:0] na4_r, nb4_r, dmag4_r;
  logic          dneg4_r, inval4_r;
  logic [TW-1:0] t1_r, t2_r;

  logic [TW-1:0] lena, lenb, t1, t2;
  logic [TW:0]   tsum;
  logic [63:0]   na_sh, nb_sh, d_sh;

  assign ra[0] = ax_i;
  assign ra[1] = ay_i;
  assign ra[2] = az_i;
  assign rb[0] = bx_i;
  assign rb[1] = by_i;
  assign rb[2] = bz_i;

  // Split components into magnitude and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = ra[i][CW-1] ? (~ra[i] + 1'b1) : ra[i];
      mb[i] = rb[i][CW-1] ? (~rb[i] + 1'b1) : rb[i];
    end
  end

  // Hold valid bits of the five front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  // Stage 1 to 3: magnitudes, products, sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        am_r[i]  <= ma[i];
        bm_r[i]  <= mb[i];
        sg_r[i]  <= ra[i][CW-1] ^ rb[i][CW-1];
        sqa_r[i] <= NW'(am_r[i]) * NW'(am_r[i]);
        sqb_r[i] <= NW'(bm_r[i]) * NW'(bm_r[i]);
        pr_r[i]  <= NW'(am_r[i]) * NW'(bm_r[i]);
      end
      sg2_r <= sg_r;
      na_r  <= sqa_r[0] + sqa_r[1] + sqa_r[2];
      nb_r  <= sqb_r[0] + sqb_r[1] + sqb_r[2];
      pos_r <= (sg2_r[0] ? '0 : pr_r[0]) + (sg2_r[1] ? '0 : pr_r[1])
             + (sg2_r[2] ? '0 : pr_r[2]);
      neg_r <= (sg2_r[0] ? pr_r[0] : '0) + (sg2_r[1] ? pr_r[1] : '0)
             + (sg2_r[2] ? pr_r[2] : '0);
    end
  end

  // Find the right shifts that bring each norm below 2^32, even total
  always_comb begin
    lena = '0;
    lenb = '0;
    for (int j = 0; j < NW; j++) begin
      if (na_r[j]) lena = TW'(j + 1);
      if (nb_r[j]) lenb = TW'(j + 1);
    end
    t1 = (int'(lena) > 32) ? TW'(int'(lena) - 32) : '0;
    t2 = (int'(lenb) > 32) ? TW'(int'(lenb) - 32) : '0;
    if (t1[0] ^ t2[0]) begin
      if (t1 >= t2) t1 = t1 + 1'b1;
      else          t2 = t2 + 1'b1;
    end
  end

  // Stage 4: dot sign and magnitude, shift amounts
  always_ff @(posedge clk) begin
    if (en) begin
      na4_r    <= na_r;
      nb4_r    <= nb_r;
      dneg4_r  <= neg_r > pos_r;
      dmag4_r  <= (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
      inval4_r <= (na_r == '0) || (nb_r == '0);
      t1_r     <= t1;
      t2_r     <= t2;
    end
  end

  // Apply the shifts
  always_comb begin
    tsum  = {1'b0, t1_r} + {1'b0, t2_r};
    na_sh = 64'(na4_r >> t1_r);
    nb_sh = 64'(nb4_r >> t2_r);
    d_sh  = 64'(dmag4_r >> (tsum >> 1));
  end

  // Stage 5: fitted values out
  always_ff @(posedge clk) begin
    if (en) begin
      na_o        <= na_sh[31:0];
      nb_o        <= nb_sh[31:0];
      dmag_o      <= d_sh[31:0];
      tag_o.inval <= inval4_r;
      tag_o.dneg  <= dneg4_r;
      tag_o.sat   <= |d_sh[63:32];
    end
  end

  assign vld_o = vld_r[4];

endmodule

// ===== rtl/vaf_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root: settles one root
// bit per beat and hands the radicand and partial root on. No dependencies.
module vaf_sqrt_cell #(
  parameter int N  = 32,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [2*N-1:0]  rad_i,
  input  logic [N:0]      rem_i,
  input  logic [N-1:0]    root_i,
  input  logic [PW-1:0]   pass_i,
  output logic            vld_o,
  output logic [2*N-1:0]  rad_o,
  output logic [N:0]      rem_o,
  output logic [N-1:0]    root_o,
  output logic [PW-1:0]   pass_o
);

  logic [N+1:0] rem_t;
  logic [N+1:0] trial;
  logic         take;

  // Bring down two radicand bits and try a one
  always_comb begin
    rem_t = {rem_i[N-1:0], rad_i[2*N-1:2*N-2]};
    trial = {root_i, 2'b01};
    take  = rem_t >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  // Advance the partial root
  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[2*N-3:0], 2'b00};
      rem_o  <= take ? (N+1)'(rem_t - trial) : rem_t[N:0];
      root_o <= {root_i[N-2:0], take};
      pass_o <= pass_i;
    end
  end

endmodule

// ===== rtl/vaf_div_cell.sv =====
// One quotient-bit cell of the restoring cosine divider.
// Depends on vaf_pkg.
module vaf_div_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic [vaf_pkg::FIT_BITS-1:0]     rem_i,
  input  logic [vaf_pkg::FIT_BITS-1:0]     den_i,
  input  logic [vaf_pkg::QUO_BITS-1:0]     quo_i,
  input  vaf_pkg::tag_t                    tag_i,
  output logic                             vld_o,
  output logic [vaf_pkg::FIT_BITS-1:0]     rem_o,
  output logic [vaf_pkg::FIT_BITS-1:0]     den_o,
  output logic [vaf_pkg::QUO_BITS-1:0]     quo_o,
  output vaf_pkg::tag_t                    tag_o
);

  localparam int W = vaf_pkg::FIT_BITS;

  logic [W:0] rem_t;
  logic       take;

  // Double the remainder and compare with the divisor
  always_comb begin
    rem_t = {rem_i, 1'b0};
    take  = rem_t >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= take ? W'(rem_t - {1'b0, den_i}) : rem_t[W-1:0];
      den_o <= den_i;
      quo_o <= {quo_i[vaf_pkg::QUO_BITS-2:0], take};
      tag_o <= tag_i;
    end
  end

endmodule

// ===== rtl/vaf_cordic_cell.sv =====
// One vectoring step of the arccosine CORDIC chain; the step's angle is a
// constant from the package table. Depends on vaf_pkg.
module vaf_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic signed [vaf_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [vaf_pkg::CORDIC_W-1:0] y_i,
  input  logic signed [vaf_pkg::CORDIC_W-1:0] z_i,
  input  vaf_pkg::tag_t                       tag_i,
  output logic                                vld_o,
  output logic signed [vaf_pkg::CORDIC_W-1:0] x_o,
  output logic signed [vaf_pkg::CORDIC_W-1:0] y_o,
  output logic signed [vaf_pkg::CORDIC_W-1:0] z_o,
  output vaf_pkg::tag_t                       tag_o
);

  localparam int          W     = vaf_pkg::CORDIC_W;
  localparam logic [31:0] ANGLE = vaf_pkg::atan_entry(STEP);

  logic signed [W-1:0] dx, dy, ang;

  assign dx  = x_i >>> STEP;
  assign dy  = y_i >>> STEP;
  assign ang = $signed({{(W-32){1'b0}}, ANGLE});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  // Rotate toward the x axis; hold once y reaches zero
  always_ff @(posedge clk) begin
    if (en) begin
      tag_o <= tag_i;
      if (y_i > 0) begin
        x_o <= x_i + dy;
        y_o <= y_i - dx;
        z_o <= z_i + ang;
      end else if (y_i < 0) begin
        x_o <= x_i - dy;
        y_o <= y_i + dx;
        z_o <= z_i - ang;
      end else begin
        x_o <= x_i;
        y_o <= y_i;
        z_o <= z_i;
      end
    end
  end

endmodule

// ===== rtl/vector_angle_fraction.sv =====
// Angle between two 3D vectors as a fraction of pi, one pipeline of cells.
// Pipeline sections in order: front end, root product, square root, divider,
// cosine square, sine root, CORDIC, output register.
// Throughput one beat per cycle; the whole chain stalls while a result waits.
// Synchronous active-low reset clears all valid bits; data registers hold.
module vector_angle_fraction #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_second_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [FRACTION_BITS:0]            out_angle_fraction,
  output logic                              out_invalid
);

  localparam int FB  = FRACTION_BITS;
  localparam int SH  = 32 - FB;
  localparam int FW  = vaf_pkg::FIT_BITS;
  localparam int QW  = vaf_pkg::QUO_BITS;
  localparam int CMW = vaf_pkg::CM_BITS;
  localparam int SNW = vaf_pkg::SN_BITS;
  localparam int CS  = vaf_pkg::CORDIC_STEPS;
  localparam int CDW = vaf_pkg::CORDIC_W;
  localparam int TGW = $bits(vaf_pkg::tag_t);
  localparam int P1W = FW + TGW;
  localparam int P2W = CMW + TGW;
  localparam logic [33:0]   ROUND = 34'd1 << (SH - 1);
  localparam logic [FB:0]   FULL  = {1'b1, {FB{1'b0}}};

  logic en;
  logic out_valid_r;
  logic [FB:0] out_angle_r;
  logic out_invalid_r;

  // Advance the whole chain whenever the output register is empty or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Front end
  logic          fe_vld;
  logic [FW-1:0] fe_na, fe_nb, fe_dmag;
  vaf_pkg::tag_t fe_tag;

  vaf_front #(.CW(COMPONENT_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid && in_ready),
    .ax_i   (in_first_x),
    .ay_i   (in_first_y),
    .az_i   (in_first_z),
    .bx_i   (in_second_x),
    .by_i   (in_second_y),
    .bz_i   (in_second_z),
    .vld_o  (fe_vld),
    .na_o   (fe_na),
    .nb_o   (fe_nb),
    .dmag_o (fe_dmag),
    .tag_o  (fe_tag)
  );

  // Product of the fitted norms
  logic            pm_vld_r;
  logic [2*FW-1:0] pm_prod_r;
  logic [FW-1:0]   pm_dmag_r;
  vaf_pkg::tag_t   pm_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_vld_r <= 1'b0;
    end else if (en) begin
      pm_vld_r <= fe_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_prod_r <= (2*FW)'(fe_na) * (2*FW)'(fe_nb);
      pm_dmag_r <= fe_dmag;
      pm_tag_r  <= fe_tag;
    end
  end

  // Square root of the norm product
  logic            r1_vld  [FW+1];
  logic [2*FW-1:0] r1_rad  [FW+1];
  logic [FW:0]     r1_rem  [FW+1];
  logic [FW-1:0]   r1_root [FW+1];
  logic [P1W-1:0]  r1_pass [FW+1];

  assign r1_vld[0]  = pm_vld_r;
  assign r1_rad[0]  = pm_prod_r;
  assign r1_rem[0]  = '0;
  assign r1_root[0] = '0;
  assign r1_pass[0] = {pm_dmag_r, pm_tag_r};

  for (genvar k = 0; k < FW; k++) begin : g_root1
    vaf_sqrt_cell #(.N(FW), .PW(P1W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (r1_vld[k]),
      .rad_i  (r1_rad[k]),
      .rem_i  (r1_rem[k]),
      .root_i (r1_root[k]),
      .pass_i (r1_pass[k]),
      .vld_o  (r1_vld[k+1]),
      .rad_o  (r1_rad[k+1]),
      .rem_o  (r1_rem[k+1]),
      .root_o (r1_root[k+1]),
      .pass_o (r1_pass[k+1])
    );
  end

  // Divider entry: clamp when the dot magnitude reaches the root
  logic [FW-1:0] dv_s, dv_d;
  vaf_pkg::tag_t dv_tag;

  always_comb begin
    dv_s       = r1_root[FW];
    dv_d       = r1_pass[FW][P1W-1:TGW];
    dv_tag     = vaf_pkg::tag_t'(r1_pass[FW][TGW-1:0]);
    dv_tag.sat = dv_tag.sat || (dv_d >= dv_s);
  end

  logic          dv_vld [QW+1];
  logic [FW-1:0] dv_rem [QW+1];
  logic [FW-1:0] dv_den [QW+1];
  logic [QW-1:0] dv_quo [QW+1];
  vaf_pkg::tag_t dv_tg  [QW+1];

  assign dv_vld[0] = r1_vld[FW];
  assign dv_rem[0] = dv_tag.sat ? '0 : dv_d;
  assign dv_den[0] = dv_s;
  assign dv_quo[0] = '0;
  assign dv_tg[0]  = dv_tag;

  for (genvar k = 0; k < QW; k++) begin : g_div
    vaf_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_vld[k]),
      .rem_i (dv_rem[k]),
      .den_i (dv_den[k]),
      .quo_i (dv_quo[k]),
      .tag_i (dv_tg[k]),
      .vld_o (dv_vld[k+1]),
      .rem_o (dv_rem[k+1]),
      .den_o (dv_den[k+1]),
      .quo_o (dv_quo[k+1]),
      .tag_o (dv_tg[k+1])
    );
  end

  // Cosine magnitude, then its square
  logic             cm_vld_r, cq_vld_r;
  logic [CMW-1:0]   cm_r, cq_cm_r;
  logic [2*CMW-1:0] cq_sq_r;
  vaf_pkg::tag_t    cm_tag_r, cq_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_vld_r <= 1'b0;
      cq_vld_r <= 1'b0;
    end else if (en) begin
      cm_vld_r <= dv_vld[QW];
      cq_vld_r <= cm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r     <= dv_tg[QW].sat ? {1'b1, {QW{1'b0}}} : {1'b0, dv_quo[QW]};
      cm_tag_r <= dv_tg[QW];
      cq_sq_r  <= (2*CMW)'(cm_r) * (2*CMW)'(cm_r);
      cq_cm_r  <= cm_r;
      cq_tag_r <= cm_tag_r;
    end
  end

  // Square root of one minus the cosine squared
  logic             r2_vld  [SNW+1];
  logic [2*SNW-1:0] r2_rad  [SNW+1];
  logic [SNW:0]     r2_rem  [SNW+1];
  logic [SNW-1:0]   r2_root [SNW+1];
  logic [P2W-1:0]   r2_pass [SNW+1];

  assign r2_vld[0]  = cq_vld_r;
  assign r2_rad[0]  = ((2*SNW)'(1) << (2*QW)) - cq_sq_r;
  assign r2_rem[0]  = '0;
  assign r2_root[0] = '0;
  assign r2_pass[0] = {cq_cm_r, cq_tag_r};

  for (genvar k = 0; k < SNW; k++) begin : g_root2
    vaf_sqrt_cell #(.N(SNW), .PW(P2W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (r2_vld[k]),
      .rad_i  (r2_rad[k]),
      .rem_i  (r2_rem[k]),
      .root_i (r2_root[k]),
      .pass_i (r2_pass[k]),
      .vld_o  (r2_vld[k+1]),
      .rad_o  (r2_rad[k+1]),
      .rem_o  (r2_rem[k+1]),
      .root_o (r2_root[k+1]),
      .pass_o (r2_pass[k+1])
    );
  end

  // CORDIC vectoring chain
  logic                  cd_vld [CS+1];
  logic signed [CDW-1:0] cd_x   [CS+1];
  logic signed [CDW-1:0] cd_y   [CS+1];
  logic signed [CDW-1:0] cd_z   [CS+1];
  vaf_pkg::tag_t         cd_tag [CS+1];

  assign cd_vld[0] = r2_vld[SNW];
  assign cd_x[0]   = $signed({{(CDW-CMW){1'b0}}, r2_pass[SNW][P2W-1:TGW]});
  assign cd_y[0]   = $signed({{(CDW-SNW){1'b0}}, r2_root[SNW]});
  assign cd_z[0]   = '0;
  assign cd_tag[0] = vaf_pkg::tag_t'(r2_pass[SNW][TGW-1:0]);

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    vaf_cordic_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (cd_vld[k]),
      .x_i   (cd_x[k]),
      .y_i   (cd_y[k]),
      .z_i   (cd_z[k]),
      .tag_i (cd_tag[k]),
      .vld_o (cd_vld[k+1]),
      .x_o   (cd_x[k+1]),
      .y_o   (cd_y[k+1]),
      .z_o   (cd_z[k+1]),
      .tag_o (cd_tag[k+1])
    );
  end

  // Clamp the angle, fold for a negative dot product, round and saturate; zero for an invalid input
  logic [31:0]   zc;
  logic [32:0]   frac;
  logic [33:0]   rnd;
  logic [FB:0]   ang;
  vaf_pkg::tag_t ft;

  always_comb begin
    ft = cd_tag[CS];
    if (cd_z[CS] < 0) begin
      zc = '0;
    end else if (cd_z[CS] > 34'sh0_8000_0000) begin
      zc = 32'h8000_0000;
    end else begin
      zc = cd_z[CS][31:0];
    end
    frac = ft.dneg ? (33'h1_0000_0000 - {1'b0, zc}) : {1'b0, zc};
    rnd  = ({1'b0, frac} + ROUND) >> SH;
    ang  = (rnd > {{(33-FB){1'b0}}, FULL}) ? FULL : rnd[FB:0];
    if (ft.inval) ang = '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cd_vld[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_angle_r   <= ang;
      out_invalid_r <= ft.inval;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_angle_fraction = out_angle_r;
  assign out_invalid        = out_invalid_r;

endmodule
